[rtl/ptsp_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptsp_pkg
// Shared types and widths for the point-to-screen projection block.
// ---------------------------------------------------------------------------
package ptsp_pkg;

    // magnitude of (p-e)*focal^2*16 and of a positive de
    localparam int NUM_W  = 52;
    localparam int DEN_W  = 34;
    // divider sideband: color, point x/y/z, three quotient signs, behind-eye flag
    localparam int SIDE_W = 60;

    // register indexes (byte address 8*i)
    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_EYE    = 3'd1;
    localparam logic [2:0] REG_TARGET = 3'd2;
    localparam logic [2:0] REG_ROWL   = 3'd3;
    localparam logic [2:0] REG_ROWM   = 3'd4;
    localparam logic [2:0] REG_OFF    = 3'd5;
    localparam logic [2:0] REG_LENS   = 3'd6;
    localparam logic [2:0] REG_SCREEN = 3'd7;

    typedef struct packed {
        logic        mode;
        logic [47:0] eye;
        logic [47:0] target;
        logic [47:0] rowl;
        logic [47:0] rowm;
        logic [63:0] off;
        logic [47:0] lens;
        logic [31:0] screen;
    } t_cfg;

    typedef struct packed {
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic signed [16:0] dz;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] pz;
        logic signed [35:0] de;
        logic [7:0]         color;
    } t_qent;

    typedef struct packed {
        logic       full;
        logic       empty;
        logic [1:0] count;
    } t_qstat;

endpackage

[rtl/point_to_screen_projection.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// point_to_screen_projection
// Perspective / isometric projection of a 3D point to screen coordinates.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------
//  input    | start & !busy      | i_point_x/y/z, i_point_color
//  result   | o_done (1 cycle)   | o_screen_x/y, o_pixel_color, o_outside
//  config   | psel&penable&pwrite| paddr (reg at 8*i), pwdata, prdata
//
//  One point per cycle sustained; o_done follows the accepting edge via the
//  front register, queue, pipelined divider (the bulk) and back stages.
//  busy stays low: the back pipeline drains the queue every cycle.
//  Reset is synchronous, active low; it loads the register defaults.
//  Results cannot be stalled by the receiver.
// ---------------------------------------------------------------------------
module point_to_screen_projection #(
    parameter int COORD_WIDTH = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  wire [15:0]         i_point_x,
    input  wire [15:0]         i_point_y,
    input  wire [15:0]         i_point_z,
    input  wire [7:0]          i_point_color,
    output logic               o_done,
    output logic signed [15:0] o_screen_x,
    output logic signed [15:0] o_screen_y,
    output logic [7:0]         o_pixel_color,
    output logic               o_outside,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire [5:0]          paddr,
    input  wire [63:0]         pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    localparam int CB = (COORD_WIDTH > 16) ? 16 : COORD_WIDTH;

    ptsp_pkg::t_cfg r_cfg;
    logic           wr;
    logic [2:0]     idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign idx    = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode   <= 1'b1;
            r_cfg.eye    <= '0;
            r_cfg.target <= '0;
            r_cfg.rowl   <= '0;
            r_cfg.rowm   <= '0;
            r_cfg.off    <= '0;
            r_cfg.lens   <= 48'd3436141638919;
            r_cfg.screen <= 32'd41943390;
        end else if (wr) begin
            case (idx)
                ptsp_pkg::REG_MODE:   r_cfg.mode   <= pwdata[0];
                ptsp_pkg::REG_EYE:    r_cfg.eye    <= pwdata[47:0];
                ptsp_pkg::REG_TARGET: r_cfg.target <= pwdata[47:0];
                ptsp_pkg::REG_ROWL:   r_cfg.rowl   <= pwdata[47:0];
                ptsp_pkg::REG_ROWM:   r_cfg.rowm   <= pwdata[47:0];
                ptsp_pkg::REG_OFF:    r_cfg.off    <= pwdata;
                ptsp_pkg::REG_LENS:   r_cfg.lens   <= pwdata[47:0];
                ptsp_pkg::REG_SCREEN: r_cfg.screen <= pwdata[31:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            ptsp_pkg::REG_MODE:   prdata = {63'b0, r_cfg.mode};
            ptsp_pkg::REG_EYE:    prdata = {16'b0, r_cfg.eye};
            ptsp_pkg::REG_TARGET: prdata = {16'b0, r_cfg.target};
            ptsp_pkg::REG_ROWL:   prdata = {16'b0, r_cfg.rowl};
            ptsp_pkg::REG_ROWM:   prdata = {16'b0, r_cfg.rowm};
            ptsp_pkg::REG_OFF:    prdata = r_cfg.off;
            ptsp_pkg::REG_LENS:   prdata = {16'b0, r_cfg.lens};
            ptsp_pkg::REG_SCREEN: prdata = {32'b0, r_cfg.screen};
            default:    prdata = '0;
        endcase
    end

    logic             accept;
    logic             push;
    ptsp_pkg::t_qent  f_ent;
    ptsp_pkg::t_qent  q_ent;
    ptsp_pkg::t_qstat q_stat;

    assign accept = start && !busy;
    // back pops every cycle the queue holds an entry
    assign busy = q_stat.full || ((q_stat.count == 2'd1) && push && q_stat.empty);

    ptsp_front #(.CB(CB)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_point_z     (i_point_z),
        .i_point_color (i_point_color),
        .i_cfg         (r_cfg),
        .o_push        (push),
        .o_ent         (f_ent)
    );

    ptsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (f_ent),
        .i_pop   (1'b1),
        .o_ent   (q_ent),
        .o_stat  (q_stat)
    );

    ptsp_back #(.CB(CB)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (!q_stat.empty),
        .i_ent         (q_ent),
        .i_cfg         (r_cfg),
        .o_done        (o_done),
        .o_screen_x    (o_screen_x),
        .o_screen_y    (o_screen_y),
        .o_pixel_color (o_pixel_color),
        .o_outside     (o_outside)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_stat.full))
        else $error("queue overflow");

    a_queue_shallow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count <= 2'd1)
        else $error("queue backed up");

    a_inside_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_outside) |-> (!o_screen_x[15] && !o_screen_y[15]))
        else $error("on-screen point with negative coordinate");

endmodule
`default_nettype wire

[rtl/ptsp_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ptsp_front
// Accepts a point, forms p-e and de = (e-t).(e-p), registers the entry.
// ---------------------------------------------------------------------------
module ptsp_front #(
    parameter int CB = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_accept,
    input  wire [15:0]          i_point_x,
    input  wire [15:0]          i_point_y,
    input  wire [15:0]          i_point_z,
    input  wire [7:0]           i_point_color,
    input  ptsp_pkg::t_cfg      i_cfg,
    output logic                o_push,
    output ptsp_pkg::t_qent     o_ent
);

    logic signed [15:0] p [3];
    logic signed [15:0] e [3];
    logic signed [15:0] t [3];
    logic signed [16:0] d [3];
    logic signed [35:0] n_de;
    logic               r_valid;
    ptsp_pkg::t_qent    r_ent;

    assign p[0] = 16'($signed(i_point_x[CB-1:0]));
    assign p[1] = 16'($signed(i_point_y[CB-1:0]));
    assign p[2] = 16'($signed(i_point_z[CB-1:0]));

    always_comb begin
        n_de = '0;
        for (int i = 0; i < 3; i++) begin
            e[i] = 16'($signed(i_cfg.eye[16*(2-i) +: CB]));
            t[i] = 16'($signed(i_cfg.target[16*(2-i) +: CB]));
            d[i] = 17'(p[i]) - 17'(e[i]);
            n_de = n_de + 36'((17'(e[i]) - 17'(t[i])) * (17'(e[i]) - 17'(p[i])));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_ent.dx    <= d[0];
            r_ent.dy    <= d[1];
            r_ent.dz    <= d[2];
            r_ent.px    <= p[0];
            r_ent.py    <= p[1];
            r_ent.pz    <= p[2];
            r_ent.de    <= n_de;
            r_ent.color <= i_point_color;
        end
    end

    assign o_push = r_valid;
    assign o_ent  = r_ent;

endmodule
`default_nettype wire

[rtl/ptsp_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ptsp_queue
// Two-entry queue between the front and the back.
// ---------------------------------------------------------------------------
module ptsp_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  ptsp_pkg::t_qent     i_ent,
    input  wire                 i_pop,
    output ptsp_pkg::t_qent     o_ent,
    output ptsp_pkg::t_qstat    o_stat
);

    ptsp_pkg::t_qent r_mem [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic [1:0]      n_cnt;
    logic            do_push;
    logic            do_pop;

    assign do_pop  = i_pop && (r_cnt != 2'd0);
    assign do_push = i_push && (r_cnt != 2'd2);

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_ent;
    end

    assign o_ent        = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);
    assign o_stat.count = r_cnt;

endmodule
`default_nettype wire

[rtl/ptsp_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ptsp_div
// Pipelined restoring divider, one quotient bit per stage, three lanes
// sharing one divisor, with a sideband carried alongside.
// ---------------------------------------------------------------------------
module ptsp_div #(
    parameter int NW = 52,
    parameter int DW = 34,
    parameter int SW = 60
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    input  wire [NW-1:0]    i_num [3],
    input  wire [DW-1:0]    i_den,
    input  wire [SW-1:0]    i_side,
    output logic            o_valid,
    output logic [NW-1:0]   o_quo [3],
    output logic [SW-1:0]   o_side
);

    logic [NW:0]   r_v;
    logic [DW-1:0] r_rem  [NW+1][3];
    logic [NW-1:0] r_nq   [NW+1][3];
    logic [DW-1:0] r_den  [NW+1];
    logic [SW-1:0] r_side [NW+1];
    logic [DW-1:0] n_rem  [NW+1][3];
    logic [NW-1:0] n_nq   [NW+1][3];
    logic [DW:0]   trial  [NW+1][3];
    logic          ge     [NW+1][3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_rem[0][l] = '0;
            n_nq[0][l]  = i_num[l];
            trial[0][l] = '0;
            ge[0][l]    = 1'b0;
        end
        for (int s = 1; s <= NW; s++) begin
            for (int l = 0; l < 3; l++) begin
                trial[s][l] = {r_rem[s-1][l], r_nq[s-1][l][NW-1]};
                ge[s][l]    = trial[s][l] >= {1'b0, r_den[s-1]};
                n_rem[s][l] = ge[s][l] ? DW'(trial[s][l] - {1'b0, r_den[s-1]})
                                       : trial[s][l][DW-1:0];
                n_nq[s][l]  = {r_nq[s-1][l][NW-2:0], ge[s][l]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[NW-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_den[0]  <= i_den;
        r_side[0] <= i_side;
        for (int s = 1; s <= NW; s++) begin
            r_den[s]  <= r_den[s-1];
            r_side[s] <= r_side[s-1];
        end
        for (int s = 0; s <= NW; s++) begin
            for (int l = 0; l < 3; l++) begin
                r_rem[s][l] <= n_rem[s][l];
                r_nq[s][l]  <= n_nq[s][l];
            end
        end
    end

    assign o_valid = r_v[NW];
    assign o_side  = r_side[NW];
    assign o_quo[0] = r_nq[NW][0];
    assign o_quo[1] = r_nq[NW][1];
    assign o_quo[2] = r_nq[NW][2];

endmodule
`default_nettype wire

[rtl/ptsp_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ptsp_back
// Perspective divide (isometric mode keeps the point), view rows, scale/aspect, screen offset and clipping.
// ---------------------------------------------------------------------------
module ptsp_back #(
    parameter int CB = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  ptsp_pkg::t_qent     i_ent,
    input  ptsp_pkg::t_cfg      i_cfg,
    output logic                o_done,
    output logic signed [15:0]  o_screen_x,
    output logic signed [15:0]  o_screen_y,
    output logic [7:0]          o_pixel_color,
    output logic                o_outside
);

    localparam int NW = ptsp_pkg::NUM_W;
    localparam int DW = ptsp_pkg::DEN_W;
    localparam int SW = ptsp_pkg::SIDE_W;

    logic [15:0] focal, scale, aspect, width, height;
    assign focal  = i_cfg.lens[47:32];
    assign scale  = i_cfg.lens[31:16];
    assign aspect = i_cfg.lens[15:0];
    assign width  = i_cfg.screen[31:16];
    assign height = i_cfg.screen[15:0];

    logic [31:0] r_ff;
    always_ff @(posedge i_clk) begin
        r_ff <= focal * focal;
    end

    // stage 0: numerator (p-e)*focal^2*16
    logic signed [16:0] d [3];
    logic signed [53:0] prod [3];
    logic               r0_v;
    logic signed [53:0] r0_num [3];
    logic signed [35:0] r0_de;
    logic signed [15:0] r0_p [3];
    logic [7:0]         r0_color;

    assign d[0] = i_ent.dx;
    assign d[1] = i_ent.dy;
    assign d[2] = i_ent.dz;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prod[i] = 54'(d[i] * $signed({1'b0, r_ff}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else begin
            r0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r0_num[i] <= prod[i] <<< 4;
        end
        r0_de    <= i_ent.de;
        r0_p[0]  <= i_ent.px;
        r0_p[1]  <= i_ent.py;
        r0_p[2]  <= i_ent.pz;
        r0_color <= i_ent.color;
    end

    // divider
    logic [NW-1:0] mag [3];
    logic [2:0]    sgn;
    logic [SW-1:0] side_in;
    logic          dv_v;
    logic [NW-1:0] quo [3];
    logic [SW-1:0] side_out;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sgn[i] = r0_num[i][53];
            mag[i] = r0_num[i][53] ? NW'(-r0_num[i]) : NW'(r0_num[i]);
        end
    end

    assign side_in = {r0_color, r0_p[0], r0_p[1], r0_p[2], sgn, (r0_de <= 36'sd1)};

    ptsp_div #(.NW(NW), .DW(DW), .SW(SW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r0_v),
        .i_num   (mag),
        .i_den   (r0_de[DW-1:0]),
        .i_side  (side_in),
        .o_valid (dv_v),
        .o_quo   (quo),
        .o_side  (side_out)
    );

    logic [7:0]         s_color;
    logic signed [15:0] s_p [3];
    logic [2:0]         s_sgn;
    logic               s_le1;
    assign {s_color, s_p[0], s_p[1], s_p[2], s_sgn, s_le1} = side_out;

    // stage 1: projected point, Q.4, saturated to +-2^31
    logic signed [15:0] e [3];
    logic signed [53:0] q [3];
    logic signed [53:0] psum [3];
    logic signed [32:0] n_pt [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            e[i] = 16'($signed(i_cfg.eye[16*(2-i) +: CB]));
            q[i] = s_sgn[i] ? -$signed({2'b0, quo[i]}) : $signed({2'b0, quo[i]});
            psum[i] = (54'(e[i]) <<< 4) + q[i];
            if (!i_cfg.mode) begin
                n_pt[i] = 33'(s_p[i]) <<< 4;
            end else if (psum[i] > 54'sd2147483648) begin
                n_pt[i] = 33'sd2147483648;
            end else if (psum[i] < -54'sd2147483648) begin
                n_pt[i] = -33'sd2147483648;
            end else begin
                n_pt[i] = 33'(psum[i]);
            end
        end
    end

    logic [6:1]         r_v;
    logic [7:0]         r_color [6:1];
    logic               r_le1   [6:1];
    logic signed [32:0] r1_pt [3];
    logic signed [48:0] r2_l [3];
    logic signed [48:0] r2_m [3];
    logic signed [41:0] r3_ux, r3_um;
    logic signed [58:0] r4_xs, r4_ys;
    logic signed [39:0] r5_x;
    logic signed [50:0] r5_t;
    logic signed [39:0] r6_x;
    logic signed [67:0] r6_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[5:1], dv_v};
        end
    end

    always_ff @(posedge i_clk) begin
        r_color[1] <= s_color;
        r_le1[1]   <= s_le1;
        for (int s = 2; s <= 6; s++) begin
            r_color[s] <= r_color[s-1];
            r_le1[s]   <= r_le1[s-1];
        end
    end

    // stage 2: row products
    logic signed [15:0] cl [3];
    logic signed [15:0] cm [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cl[i] = $signed(i_cfg.rowl[16*(2-i) +: 16]);
            cm[i] = $signed(i_cfg.rowm[16*(2-i) +: 16]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_pt[i] <= n_pt[i];
            r2_l[i]  <= 49'(cl[i] * r1_pt[i]);
            r2_m[i]  <= 49'(cm[i] * r1_pt[i]);
        end
    end

    // stage 3: sums, /1024 toward zero, offsets
    logic signed [50:0] dl, dm;
    logic signed [40:0] dlq, dmq;
    assign dl  = 51'(r2_l[0]) + 51'(r2_l[1]) + 51'(r2_l[2]);
    assign dm  = 51'(r2_m[0]) + 51'(r2_m[1]) + 51'(r2_m[2]);
    assign dlq = 41'((dl + (dl[50] ? 51'sd1023 : 51'sd0)) >>> 10);
    assign dmq = 41'((dm + (dm[50] ? 51'sd1023 : 51'sd0)) >>> 10);

    always_ff @(posedge i_clk) begin
        r3_ux <= 42'(dlq) + 42'($signed(i_cfg.off[63:32]));
        r3_um <= 42'(dmq) + 42'($signed(i_cfg.off[31:0]));
    end

    // stage 4: scale
    always_ff @(posedge i_clk) begin
        r4_xs <= 59'(r3_ux * $signed({1'b0, scale}));
        r4_ys <= 59'(r3_um * $signed({1'b0, scale}));
    end

    // stage 5: x centering and /2^20; y /2^8
    logic signed [59:0] xsum;
    assign xsum = 60'(r4_xs) + $signed({25'b0, width[15:1], 20'b0});

    always_ff @(posedge i_clk) begin
        r5_x <= 40'((xsum + (xsum[59] ? 60'sd1048575 : 60'sd0)) >>> 20);
        r5_t <= 51'((r4_ys + (r4_ys[58] ? 59'sd255 : 59'sd0)) >>> 8);
    end

    // stage 6: aspect
    always_ff @(posedge i_clk) begin
        r6_x <= r5_x;
        r6_v <= 68'(r5_t * $signed({1'b0, aspect}));
    end

    // stage 7: y centering, clipping, output saturation
    logic signed [62:0] vs;
    logic signed [63:0] ysum;
    logic signed [37:0] ys;
    logic               off_scr;
    logic signed [15:0] sx, sy;

    always_comb begin
        if (r6_v > (68'sd1 <<< 61)) begin
            vs = 63'sd1 <<< 61;
        end else if (r6_v < -(68'sd1 <<< 61)) begin
            vs = -(63'sd1 <<< 61);
        end else begin
            vs = 63'(r6_v);
        end
        ysum = 64'(vs) + $signed({23'b0, height[15:1], 26'b0});
        ys   = 38'((ysum + (ysum[63] ? 64'sd67108863 : 64'sd0)) >>> 26);
        off_scr = (r6_x > $signed({24'b0, width})) || r6_x[39]
               || (ys > $signed({22'b0, height})) || ys[37];
        if (r6_x < -40'sd32768) begin
            sx = 16'sh8000;
        end else if (r6_x > 40'sd32767) begin
            sx = 16'sh7fff;
        end else begin
            sx = r6_x[15:0];
        end
        // y clamps symmetric at +-32767; only values below -32768 give -32768
        if (ys < -38'sd32768) begin
            sy = 16'sh8000;
        end else if (ys == -38'sd32768) begin
            sy = 16'sh8001;
        end else if (ys > 38'sd32767) begin
            sy = 16'sh7fff;
        end else begin
            sy = ys[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_v[6];
        end
    end

    always_ff @(posedge i_clk) begin
        o_pixel_color <= r_color[6];
        if (r_le1[6]) begin
            o_screen_x <= '0;
            o_screen_y <= '0;
            o_outside  <= 1'b1;
        end else begin
            o_screen_x <= sx;
            o_screen_y <= sy;
            o_outside  <= off_scr;
        end
    end

endmodule
`default_nettype wire

[dv/ptsp_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptsp_checker
// Shadows the register file from the APB port, computes the expected screen
// point of every accepted transaction and compares it with each o_done
// result, in order.
// ---------------------------------------------------------------------------
module ptsp_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    input  wire         busy,
    input  wire [15:0]  i_point_x,
    input  wire [15:0]  i_point_y,
    input  wire [15:0]  i_point_z,
    input  wire [7:0]   i_point_color,
    input  wire         o_done,
    input  wire [15:0]  o_screen_x,
    input  wire [15:0]  o_screen_y,
    input  wire [7:0]   o_pixel_color,
    input  wire         o_outside,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [5:0]   paddr,
    input  wire [63:0]  pwdata,
    input  wire         pready,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic [15:0] sx;
        logic [15:0] sy;
        logic [7:0]  color;
        logic        outside;
    } t_screen_pt;

    ptsp_pkg::t_cfg cfg;
    t_screen_pt     screen_q[$];
    int             err_cnt = 0;

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic t_screen_pt project_point(logic [15:0] px, logic [15:0] py,
                                                 logic [15:0] pz, logic [7:0] col);
        longint     p[3], e[3], t[3], pt[3];
        longint     de, dl, dm, ux, um, xs, ys, v, q;
        longint     focal, scale, aspect, width, height;
        t_screen_pt r;
        de = 0; dl = 0; dm = 0;
        focal  = longint'(cfg.lens[47:32]);
        scale  = longint'(cfg.lens[31:16]);
        aspect = longint'(cfg.lens[15:0]);
        width  = longint'(cfg.screen[31:16]);
        height = longint'(cfg.screen[15:0]);
        p[0] = longint'($signed(px));
        p[1] = longint'($signed(py));
        p[2] = longint'($signed(pz));
        for (int i = 0; i < 3; i++) begin
            e[i] = longint'($signed(cfg.eye[47 - 16*i -: 16]));
            t[i] = longint'($signed(cfg.target[47 - 16*i -: 16]));
            de += (e[i] - t[i]) * (e[i] - p[i]);
        end
        r.color = col;
        if (de <= 1) begin
            // behind the eye
            r.sx = '0;
            r.sy = '0;
            r.outside = 1'b1;
            return r;
        end
        for (int i = 0; i < 3; i++) begin
            if (cfg.mode) begin
                q = ((p[i] - e[i]) * focal * focal * 16) / de;
                pt[i] = clamp(e[i] * 16 + q, -(64'sd1 <<< 31), 64'sd1 <<< 31);
            end else begin
                pt[i] = p[i] * 16;
            end
            dl += longint'($signed(cfg.rowl[47 - 16*i -: 16])) * pt[i];
            dm += longint'($signed(cfg.rowm[47 - 16*i -: 16])) * pt[i];
        end
        ux = dl / 1024 + longint'($signed(cfg.off[63:32]));
        um = dm / 1024 + longint'($signed(cfg.off[31:0]));
        xs = (ux * scale + ((width / 2) <<< 20)) / (64'sd1 <<< 20);
        v  = clamp(((um * scale) / 256) * aspect, -(64'sd1 <<< 61), 64'sd1 <<< 61);
        ys = (v + ((height / 2) <<< 26)) / (64'sd1 <<< 26);
        r.outside = (xs > width || xs < 0 || ys > height || ys < 0);
        r.sx = 16'(clamp(xs, -32768, 32767));
        // y clamps symmetric; only values below -32768 give -32768
        r.sy = 16'(clamp(ys, -32767, 32767));
        if (ys < -32768) r.sy = 16'h8000;
        return r;
    endfunction

    assign o_pending = screen_q.size();
    assign o_errors  = err_cnt;

    always @(posedge i_clk) begin
        t_screen_pt exp_pt;
        if (!i_rst_n) begin
            cfg.mode   <= 1'b1;
            cfg.eye    <= '0;
            cfg.target <= '0;
            cfg.rowl   <= '0;
            cfg.rowm   <= '0;
            cfg.off    <= '0;
            cfg.lens   <= 48'd3436141638919;
            cfg.screen <= 32'd41943390;
            screen_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[5:3])
                    ptsp_pkg::REG_MODE:   cfg.mode   <= pwdata[0];
                    ptsp_pkg::REG_EYE:    cfg.eye    <= pwdata[47:0];
                    ptsp_pkg::REG_TARGET: cfg.target <= pwdata[47:0];
                    ptsp_pkg::REG_ROWL:   cfg.rowl   <= pwdata[47:0];
                    ptsp_pkg::REG_ROWM:   cfg.rowm   <= pwdata[47:0];
                    ptsp_pkg::REG_OFF:    cfg.off    <= pwdata;
                    ptsp_pkg::REG_LENS:   cfg.lens   <= pwdata[47:0];
                    ptsp_pkg::REG_SCREEN: cfg.screen <= pwdata[31:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                screen_q.push_back(project_point(i_point_x, i_point_y, i_point_z,
                                                 i_point_color));
            if (o_done) begin
                if (screen_q.size() == 0) begin
                    err_cnt <= err_cnt + 1;
                    $display("%0t: unexpected result x=%0d y=%0d color=%0d outside=%0b",
                             $time, $signed(o_screen_x), $signed(o_screen_y),
                             o_pixel_color, o_outside);
                end else begin
                    exp_pt = screen_q.pop_front();
                    if (exp_pt !== {o_screen_x, o_screen_y, o_pixel_color, o_outside}) begin
                        err_cnt <= err_cnt + 1;
                        $display("%0t: mismatch exp x=%0d y=%0d color=%0d outside=%0b",
                                 $time, $signed(exp_pt.sx), $signed(exp_pt.sy),
                                 exp_pt.color, exp_pt.outside);
                        $display("%0t:          got x=%0d y=%0d color=%0d outside=%0b",
                                 $time, $signed(o_screen_x), $signed(o_screen_y),
                                 o_pixel_color, o_outside);
                    end
                end
            end
        end
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Projection block test: runs directed and random points through several
// register settings (defaults, plain perspective, isometric, random and
// extreme), with random input gaps and back-to-back bursts; the checker predicts and compares.
// ---------------------------------------------------------------------------
module tb;

    localparam int WATCHDOG_LIMIT = 3000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [15:0] i_point_x = '0, i_point_y = '0, i_point_z = '0;
    logic [7:0]  i_point_color = '0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    wire         busy, o_done, o_outside, pready;
    wire [15:0]  o_screen_x, o_screen_y;
    wire [7:0]   o_pixel_color;
    wire [63:0]  prdata;
    int          errors, pending;
    int          quiet_cycles = 0;
    bit          gaps_on = 1'b1;

    point_to_screen_projection dut (.*);

    ptsp_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_point_x, .i_point_y, .i_point_z,
        .i_point_color, .o_done, .o_screen_x, .o_screen_y, .o_pixel_color,
        .o_outside, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // watchdog: cycles with no transaction on any port
    initial begin
        forever begin
            @(posedge i_clk);
            if ((start && !busy) || o_done || (psel && penable) || !i_rst_n)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        bit rdy;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            rdy = pready;
            @(posedge i_clk);
        end while (!rdy);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic logic [47:0] pack3(int a, int b, int c);
        return {16'(a), 16'(b), 16'(c)};
    endfunction

    task automatic send_point(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                              logic [7:0] col);
        bit ok;
        if (gaps_on && $urandom_range(0, 99) < 35) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_point_x     <= x;
        i_point_y     <= y;
        i_point_z     <= z;
        i_point_color <= col;
        do begin
            @(negedge i_clk);
            ok = !busy;
            @(posedge i_clk);
        end while (!ok);
    endtask

    // mostly points near the origin, some anywhere in the field range
    task automatic send_random(int n, int span);
        for (int k = 0; k < n; k++) begin
            gaps_on = !(k >= n / 3 && k < n / 3 + 80);
            if ($urandom_range(0, 3) == 0)
                send_point(16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
            else
                send_point(16'($urandom_range(0, 2 * span) - span),
                           16'($urandom_range(0, 2 * span) - span),
                           16'($urandom_range(0, 2 * span) - span), 8'($urandom));
        end
        start <= 1'b0;
        @(posedge i_clk);
        gaps_on = 1'b1;
    endtask

    task automatic send_extremes();
        send_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 8'hFF);
        send_point(16'h8000, 16'h8000, 16'h8000, 8'h00);
        send_point(16'h0000, 16'h0000, 16'h0000, 8'hA5);
        send_point(16'h7FFF, 16'h8000, 16'h0001, 8'h5A);
        send_point(16'hFFFF, 16'h0001, 16'h8000, 8'h01);
        // just in front of / behind the eye on z
        send_point(16'h0000, 16'h0000, 16'hFFFF, 8'h11);
        send_point(16'h7FFF, 16'h8000, 16'hFFFF, 8'h22);
        send_point(16'h0000, 16'h0000, 16'h0001, 8'h33);
        send_point(16'h0000, 16'h0000, 16'h0002, 8'h44);
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all(logic mode, logic [47:0] eye, logic [47:0] tgt,
                             logic [47:0] rowl, logic [47:0] rowm, logic [63:0] off,
                             logic [47:0] lens, logic [31:0] scr);
        write_reg(ptsp_pkg::REG_MODE, {63'd0, mode});
        write_reg(ptsp_pkg::REG_EYE, {16'd0, eye});
        write_reg(ptsp_pkg::REG_TARGET, {16'd0, tgt});
        write_reg(ptsp_pkg::REG_ROWL, {16'd0, rowl});
        write_reg(ptsp_pkg::REG_ROWM, {16'd0, rowm});
        write_reg(ptsp_pkg::REG_OFF, off);
        write_reg(ptsp_pkg::REG_LENS, {16'd0, lens});
        write_reg(ptsp_pkg::REG_SCREEN, {32'd0, scr});
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: eye on target, every point lands behind the eye
        send_extremes();
        send_random(20, 2000);
        drain();

        // plain perspective, eye on +z looking at the origin
        write_all(1'b1, pack3(0, 0, 3200), pack3(0, 0, 0), pack3(16384, 0, 0),
                  pack3(0, 16384, 0), 64'd0, {16'd1600, 16'd256, 16'd16384},
                  {16'd640, 16'd350});
        send_extremes();
        send_random(320, 1600);
        drain();

        // isometric, offsets shifting the view
        write_all(1'b0, pack3(0, 0, 3200), pack3(0, 0, 0), pack3(11585, 0, -11585),
                  pack3(-6689, 13377, -6689), {32'sd409600, -32'sd204800},
                  {16'd800, 16'd512, 16'd9000}, {16'd800, 16'd600});
        send_random(250, 800);
        drain();

        // random settings
        for (int ph = 0; ph < 3; ph++) begin
            write_all(1'($urandom), 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                      48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                      {$urandom, $urandom}, 48'({$urandom, $urandom}), $urandom);
            send_random(80, 32767);
            drain();
        end

        // extremes: near-singular perspective, largest scale and aspect, tiny screen
        write_all(1'b1, pack3(0, 0, 1), pack3(0, 0, 0), {48{1'b1}} >> 1 | 48'h7FFF_7FFF_7FFF,
                  48'h8000_8000_8000, {32'h7FFF_FFFF, 32'h8000_0000},
                  {48{1'b1}}, 32'd0);
        send_extremes();
        send_random(90, 32767);
        drain();

        write_all(1'b0, pack3(-32768, -32768, -32768), pack3(32767, 32767, 32767),
                  48'h7FFF_8000_7FFF, 48'h8000_7FFF_8000, 64'd0, 48'd0, 32'hFFFF_FFFF);
        send_extremes();
        send_random(90, 32767);
        drain();

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
